// File: src/plgs_pkg.sv
// Shared types and constants for the parity life generation step.
// No dependencies; used by the top level, the result queue and the bench.
`timescale 1ns / 1ps
`default_nettype none

package plgs_pkg;

  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_INDEX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam int unsigned DIM_MIN = 3;

  // Output queue: holds up to two results per item plus slack
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic new_cell;
    logic row_last;
    logic frame_last;
  } result_t;

  // Results released by one item: first is the cell left of the input,
  // second is the last cell of the row at the right edge
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

  // Position flags of an item held in the input stage
  typedef struct packed {
    logic alive;
    logic col_zero;
    logic col_last;
    logic row_ge1;
    logic row_ge2;
    logic row_is_pad;
  } item_t;

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    int unsigned x;
    x = 32'(v);
    if (x < DIM_MIN) begin
      return DIM_MIN;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// File: src/plgs_line_store.sv
// Two-row line store: bit 1 holds the row two back, bit 0 the row one back.
// One write and one registered read per cycle. Does not use plgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plgs_line_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [1:0]        rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [1:0]        wr_data
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the read data while the input stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/plgs_result_fifo.sv
// Small result queue: takes up to two results a cycle, sends one.
// Depends on plgs_pkg for result_t, push_t and the queue sizes.
`timescale 1ns / 1ps
`default_nettype none

module plgs_result_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire plgs_pkg::push_t  push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output plgs_pkg::result_t     out_data
);

  plgs_pkg::result_t                     slots [plgs_pkg::FIFO_DEPTH];
  logic [plgs_pkg::FIFO_PTR_W-1:0]       wr_ptr;
  logic [plgs_pkg::FIFO_PTR_W-1:0]       rd_ptr;
  logic [plgs_pkg::FIFO_CNT_W-1:0]       count;
  logic [plgs_pkg::FIFO_PTR_W-1:0]       second_ptr;
  logic [plgs_pkg::FIFO_CNT_W-1:0]       push_n;
  logic                                  pop;

  assign pop        = out_valid && out_ready;
  assign push_n     = plgs_pkg::FIFO_CNT_W'(push.first_valid)
                    + plgs_pkg::FIFO_CNT_W'(push.second_valid);
  assign second_ptr = wr_ptr + plgs_pkg::FIFO_PTR_W'(push.first_valid);
  assign room       = count <= plgs_pkg::FIFO_CNT_W'(plgs_pkg::FIFO_DEPTH - 2);
  assign out_valid  = count != '0;
  assign out_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      slots[second_ptr] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[plgs_pkg::FIFO_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + push_n - plgs_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// File: src/parity_life_generation_step_top.sv
// Parity cellular automaton, one generation over a raster-order stream.
// Channels: s_* carries input cells (tdata bit 0 cell_value, tuser pad_row);
// m_* carries results (tdata bit 0 new_cell, tlast row_last, tuser
// frame_last). cfg_we/cfg_index/cfg_wdata write grid_width (index 0) and
// grid_height (index 1); a write restarts the frame.
// The producer sends grid_height rows of grid_width cells and then one
// padding row. Output row r comes out while input row r+1 arrives: result
// for column c-1 with input column c, plus the last column at the right edge.
// A result passes the input stage, where the line store read joins the
// input, and then the result queue before it can leave. Throughput: one cell
// per cycle while the queue has room; an item at the right edge pushes two
// results and the first column of the next row pushes none, so a
// receiver that takes one result per cycle never stalls the input.
// The line store is a single-port-write, registered-read memory of
// WIDTH_CAP two-bit entries; rows not yet received in a frame are gated to
// zero, so it needs no clearing after reset.
// Reset clears the counters, the window, the input stage and the queue and
// sets both dimensions to 255. When the receiver stalls, results fill the
// queue and s_tready falls once fewer than two entries are free.
`timescale 1ns / 1ps
`default_nettype none

module parity_life_generation_step_top #(
  parameter int unsigned WIDTH_CAP  = 1024,
  parameter int unsigned HEIGHT_CAP = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // [0] cell_value
  input  wire logic                                s_tuser,   // [0] pad_row
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata,   // [0] new_cell
  output logic                                     m_tlast,   // row_last
  output logic                                     m_tuser,   // [0] frame_last
  input  wire logic                                cfg_we,
  input  wire logic [plgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [plgs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(WIDTH_CAP);
  localparam int unsigned WID_W  = $clog2(WIDTH_CAP + 1);
  localparam int unsigned ROW_W  = $clog2(HEIGHT_CAP + 1);
  localparam int unsigned W_RST  = (255 > WIDTH_CAP) ? WIDTH_CAP : 255;
  localparam int unsigned H_RST  = (255 > HEIGHT_CAP) ? HEIGHT_CAP : 255;

  logic [WID_W-1:0]   width;
  logic [ROW_W-1:0]   height;
  logic [ADDR_W-1:0]  col;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  col_eff;
  logic [ROW_W-1:0]   row_eff;
  logic               col_last;
  logic               restart;
  logic               accept;
  logic               consume;
  logic               room;

  plgs_pkg::item_t    item;
  plgs_pkg::item_t    item_next;
  logic               item_valid;
  logic [ADDR_W-1:0]  item_col;

  logic [1:0]         rows_rd;
  logic [2:0]         window;
  logic [2:0]         win_next;
  logic               above2;
  logic               above1;
  logic               col_par;

  plgs_pkg::push_t    push;
  plgs_pkg::result_t  out_data;

  assign restart = cfg_we &&
                   (cfg_index == plgs_pkg::REG_GRID_WIDTH ||
                    cfg_index == plgs_pkg::REG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WID_W'(W_RST);
      height <= ROW_W'(H_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        plgs_pkg::REG_GRID_WIDTH: begin
          width <= WID_W'(plgs_pkg::clamp_dim(cfg_wdata, WIDTH_CAP));
        end
        plgs_pkg::REG_GRID_HEIGHT: begin
          height <= ROW_W'(plgs_pkg::clamp_dim(cfg_wdata, HEIGHT_CAP));
        end
        default: begin
        end
      endcase
    end
  end

  // ---- position of the incoming item
  assign col_eff  = (WID_W'(col) >= width) ? '0 : col;
  assign row_eff  = (row > height) ? '0 : row;
  assign col_last = (WID_W'(col_eff) + WID_W'(1)) == width;

  assign consume  = item_valid && room;
  assign s_tready = !item_valid || consume;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    item_next.alive      = s_tdata[0] && !s_tuser && (row_eff < height);
    item_next.col_zero   = col_eff == '0;
    item_next.col_last   = col_last;
    item_next.row_ge1    = row_eff >= ROW_W'(1);
    item_next.row_ge2    = row_eff >= ROW_W'(2);
    item_next.row_is_pad = row_eff == height;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= (row_eff == height) ? '0 : row_eff + ROW_W'(1);
      end else begin
        col <= col_eff + ADDR_W'(1);
        row <= row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= item_next;
      item_col <= col_eff;
    end
  end

  plgs_line_store #(
    .DEPTH  (WIDTH_CAP),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_eff),
    .rd_data (rows_rd),
    .wr_en   (consume),
    .wr_addr (item_col),
    .wr_data ({rows_rd[0], item.alive})
  );

  // ---- column parity window and results
  assign above2   = item.row_ge2 && rows_rd[1];
  assign above1   = item.row_ge1 && rows_rd[0];
  assign col_par  = above2 ^ above1 ^ item.alive;
  assign win_next = {(item.col_zero ? 2'b00 : window[1:0]), col_par};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (consume) begin
      window <= win_next;
    end
  end

  always_comb begin
    push.first_valid        = consume && item.row_ge1 && !item.col_zero;
    push.second_valid       = consume && item.row_ge1 && item.col_last;
    push.first.new_cell     = ~(^win_next);
    push.first.row_last     = 1'b0;
    push.first.frame_last   = 1'b0;
    push.second.new_cell    = ~(win_next[0] ^ win_next[1]);
    push.second.row_last    = 1'b1;
    push.second.frame_last  = item.row_is_pad;
  end

  plgs_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {7'b0, out_data.new_cell};
  assign m_tlast = out_data.row_last;
  assign m_tuser = out_data.frame_last;

endmodule

`default_nettype wire

// File: src/plgs_checker.sv
// Port-level checks for parity_life_generation_step_top, bound to the top.
// Depends only on the port list of the top level.
`timescale 1ns / 1ps
`default_nettype none

module plgs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // the end of a frame is always the end of a row
  a_frame_ends_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("frame_last without row_last");

  // no result is offered right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // the block is ready for input right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind parity_life_generation_step_top plgs_checker u_plgs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .m_tuser   (m_tuser)
);

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for parity_life_generation_step_top: streams grids, predicts
// each next-generation cell and compares every result transfer in order.
// Depends on plgs_pkg and the top level under src.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_W     = 1024;
  localparam int unsigned MAX_H     = 1024;
  localparam int unsigned DRAIN_CYC = 8;
  localparam int unsigned DIM_W     = plgs_pkg::CFG_DATA_W;
  localparam int unsigned IDX_W     = plgs_pkg::CFG_INDEX_W;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = 8'd0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]  cfg_wdata = '0;

  parity_life_generation_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Predictor state
  bit                  store_two [MAX_W];
  bit                  store_one [MAX_W];
  bit [2:0]            par_win;
  int unsigned         col_pos;
  int unsigned         row_pos;
  bit [DIM_W-1:0]      width_reg  = 11'd255;
  bit [DIM_W-1:0]      height_reg = 11'd255;
  plgs_pkg::result_t   next_gen_cells [$];

  int unsigned         mismatches;
  int unsigned         items_sent;
  int unsigned         burst_left;
  bit                  tx_gaps = 1'b1;
  bit                  rx_hold_ready;
  bit [7:0]            rx_pattern = 8'hFF;
  int unsigned         rx_span;
  plgs_pkg::result_t   got_cell;
  plgs_pkg::result_t   want_cell;

  function automatic int unsigned effective_dim(bit [DIM_W-1:0] raw, int unsigned hi);
    if (raw < 3) begin
      return 3;
    end
    if (raw > hi) begin
      return hi;
    end
    return raw;
  endfunction

  // Work out the results released by one input cell and advance the position
  task automatic next_generation(input bit alive, input bit pad);
    int unsigned       w;
    int unsigned       h;
    int unsigned       c;
    int unsigned       r;
    bit                v;
    bit                a;
    bit                b;
    bit [2:0]          win;
    plgs_pkg::result_t res;
    w = effective_dim(width_reg, MAX_W);
    h = effective_dim(height_reg, MAX_H);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos > h) ? 0 : row_pos;
    v = alive && !pad && (r < h);
    a = (r >= 2) ? store_two[c] : 1'b0;
    b = (r >= 1) ? store_one[c] : 1'b0;
    win = (c == 0) ? 3'd0 : par_win;
    win = {win[1:0], a ^ b ^ v};
    par_win = win;
    if (r >= 1) begin
      if (c >= 1) begin
        res.new_cell   = ~(win[0] ^ win[1] ^ win[2]);
        res.row_last   = 1'b0;
        res.frame_last = 1'b0;
        next_gen_cells.push_back(res);
      end
      // right edge: the last column has nothing to its right
      if (c == w - 1) begin
        res.new_cell   = ~(win[0] ^ win[1]);
        res.row_last   = 1'b1;
        res.frame_last = (r == h);
        next_gen_cells.push_back(res);
      end
    end
    store_two[c] = store_one[c];
    store_one[c] = v;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r > h) begin
        r = 0;
      end
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Receiver: rotating stall pattern, reloaded now and then
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_span    = $urandom_range(16, 96);
      rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    end else begin
      rx_span--;
    end
    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
    m_tready <= rx_hold_ready | rx_pattern[0];
  end

  task automatic note_mismatch(input string what, input plgs_pkg::result_t want,
                               input plgs_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected cell %0b row_last %0b frame_last %0b, got %0b %0b %0b",
               $realtime, what, want.new_cell, want.row_last, want.frame_last,
               got.new_cell, got.row_last, got.frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_cell.new_cell   = m_tdata[0];
      got_cell.row_last   = m_tlast;
      got_cell.frame_last = m_tuser;
      if (next_gen_cells.size() == 0) begin
        note_mismatch("unexpected result", '0, got_cell);
      end else begin
        want_cell = next_gen_cells.pop_front();
        if (got_cell.new_cell != want_cell.new_cell ||
            got_cell.row_last != want_cell.row_last ||
            got_cell.frame_last != want_cell.frame_last) begin
          note_mismatch("result mismatch", want_cell, got_cell);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cell(input bit alive, input bit pad);
    if (tx_gaps && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tdata  <= {7'd0, alive};
    s_tuser  <= pad;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    next_generation(alive, pad);
    items_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  task automatic hold_until_drained;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (next_gen_cells.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == plgs_pkg::REG_GRID_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
    col_pos = 0;
    row_pos = 0;
    par_win = 3'd0;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Quiesce first: cells that release nothing may still be in flight
  task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    hold_until_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    write_reg(plgs_pkg::REG_GRID_WIDTH, w);
    write_reg(plgs_pkg::REG_GRID_HEIGHT, h);
  endtask

  // One frame of random content from the start; cut > 0 stops after that many cells
  task automatic send_frame(input int unsigned ones_pct, input int unsigned noise_pct,
                            input int unsigned cut);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = effective_dim(width_reg, MAX_W);
    h = effective_dim(height_reg, MAX_H);
    n = 0;
    for (int unsigned r = 0; r <= h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (cut != 0 && n == cut) begin
          return;
        end
        if (r < h) begin
          send_cell($urandom_range(0, 99) < ones_pct, $urandom_range(0, 99) < noise_pct);
        end else begin
          send_cell(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
        end
        if ($urandom_range(0, 299) == 0) begin
          hold_until_drained();
        end
        n++;
      end
    end
  endtask

  function automatic logic [DIM_W-1:0] pick_dim;
    case ($urandom_range(0, 9))
      0:       return DIM_W'($urandom_range(0, 2));
      1:       return DIM_W'($urandom_range(13, 24));
      default: return DIM_W'($urandom_range(3, 12));
    endcase
  endfunction

  // Reset dimensions of 255 x 255: one full row then part of the next
  task automatic test_reset_dimensions;
    repeat (262) send_cell(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic test_all_alive_grid;
    set_grid(11'd3, 11'd3);
    repeat (9) send_cell(1'b1, 1'b0);
    repeat (3) send_cell(1'b1, 1'b1);
  endtask

  // Misplaced pad mark inside the grid, unmarked padding row carrying ones
  task automatic test_pad_markers;
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    repeat (3) send_cell(1'b1, 1'b0);
  endtask

  // Random grids until the budget of cells is spent; any frame may stop early
  task automatic test_random_frames(input int unsigned budget);
    int unsigned start;
    int unsigned left;
    int unsigned cut;
    bit          cut_short;
    start     = items_sent;
    cut_short = 1'b1;
    while (items_sent - start < budget) begin
      if (cut_short || $urandom_range(0, 3) != 0) begin
        set_grid(pick_dim(), pick_dim());
      end
      cut_short = ($urandom_range(0, 7) == 0);
      left      = budget - (items_sent - start);
      cut       = cut_short ? $urandom_range(1, 20) : 0;
      if (cut == 0 || cut > left) begin
        cut = left;
      end
      send_frame($urandom_range(5, 95), $urandom_range(0, 1) * 5, cut);
    end
  endtask

  // Clamped extremes, run without idling: oversize width releases nothing in
  // the first row, zero height acts as three rows, oversize height never ends early
  task automatic test_extreme_dims;
    tx_gaps       = 1'b0;
    rx_hold_ready = 1'b1;
    set_grid(11'd2047, 11'd0);
    send_frame(50, 2, 40);
    set_grid(11'd3, 11'd0);
    send_frame(50, 2, 0);
    set_grid(11'd3, 11'd2047);
    send_frame(50, 2, 30);
    tx_gaps       = 1'b1;
    rx_hold_ready = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_dimensions();
    test_all_alive_grid();
    test_pad_markers();
    test_random_frames(80);
    test_extreme_dims();
    test_random_frames(80);
    hold_until_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    if (mismatches == 0 && next_gen_cells.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: parity_life_generation_step_top.f
src/plgs_pkg.sv
src/plgs_line_store.sv
src/plgs_result_fifo.sv
src/parity_life_generation_step_top.sv
src/plgs_checker.sv
bench/tb_top.sv
